>>> src/htdr_pkg.sv
// shared types, constants and codes for the hashed table with depth replacement
// no dependencies
package htdr_pkg;

   localparam int TableDepth = 65536;
   localparam int IdxWidth   = $clog2(TableDepth);
   localparam int EntriesW   = 17;
   localparam int ProdWidth  = 32 + EntriesW;
   localparam int CsrIdxW    = 2;
   localparam int CsrDataW   = 17;

   localparam logic OpProbe = 1'b0;
   localparam logic OpSave  = 1'b1;

   localparam logic [1:0] FlagExact = 2'd3;

   localparam logic [CsrIdxW-1:0] CsrTableEntries  = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrMateThreshold = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrDepthLenience = 2'd2;

   localparam logic [EntriesW-1:0] EntriesReset   = 17'd65536;
   localparam logic [14:0]         ThresholdReset = 15'd31744;
   localparam logic [3:0]          LenienceReset  = 4'd4;

   typedef enum logic [1:0] {
      BackClear,
      BackIdle,
      BackEval
   } back_state_type;

   typedef struct packed {
      logic               op;
      logic [63:0]        key;
      logic [7:0]         new_depth;
      logic [1:0]         new_flag;
      logic [15:0]        new_move;
      logic signed [15:0] new_score;
      logic [7:0]         ply;
   } req_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic                op;
      logic [63:0]         key;
      logic [7:0]          depth;
      logic [1:0]          flag;
      logic [15:0]         move;
      logic signed [15:0]  score;
      logic [IdxWidth-1:0] index;
   } item_type;

   typedef struct packed {
      logic [63:0]        key;
      logic [7:0]         depth;
      logic [1:0]         flag;
      logic [15:0]        move;
      logic signed [15:0] score;
   } entry_type;

   typedef struct packed {
      logic      hit;
      entry_type stored;
      logic      replaced;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

>>> src/htdr_front.sv
// front end: accepts request words, computes the slot index and the ply-corrected score
// depends on htdr_pkg
module htdr_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  htdr_pkg::req_type              req_word,
   input  logic [htdr_pkg::EntriesW-1:0]  table_entries,
   input  logic [14:0]                    mate_threshold,
   input  htdr_pkg::queue_status_type     q_status,
   input  htdr_pkg::back_status_type      back_status,
   output logic                           q_push,
   output htdr_pkg::item_type             q_item
);
   import htdr_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   req_type              s1_req_ff;
   logic [ProdWidth-1:0] prod_hi_ff, prod_lo_ff;
   logic [EntriesW-1:0]  n_used;
   logic                 req_accept;
   logic [ProdWidth:0]   mid;
   logic [ProdWidth-32:0] idx_full;
   logic signed [17:0]   s_ext, t_ext, neg_t, ply_ext, adj;
   logic signed [15:0]   score_sat;

   // zero scales as one slot, oversize saturates to the table size
   always_comb begin
      if (table_entries == '0) begin
         n_used = EntriesW'(1);
      end else if (32'(table_entries) > TableDepth) begin
         n_used = EntriesW'(TableDepth);
      end else begin
         n_used = table_entries;
      end
   end

   assign req_stall  = back_status.clearing || (s1_valid_ff && q_status.full);
   assign req_accept = req_valid && !req_stall;
   assign q_push     = s1_valid_ff && !q_status.full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff  <= req_word;
         prod_hi_ff <= ProdWidth'(req_word.key[63:32]) * ProdWidth'(n_used);
         prod_lo_ff <= ProdWidth'(req_word.key[31:0]) * ProdWidth'(n_used);
      end
   end

   // bits of key * n above 2^64, formed from two partial products, give the slot
   always_comb begin
      mid      = (ProdWidth+1)'(prod_hi_ff) + (ProdWidth+1)'(prod_lo_ff[ProdWidth-1:32]);
      idx_full = mid[ProdWidth:32];
   end

   // mate scores move outward by ply, then saturate to the symmetric range
   always_comb begin
      s_ext   = {{2{s1_req_ff.new_score[15]}}, s1_req_ff.new_score};
      t_ext   = {3'b000, mate_threshold};
      neg_t   = -t_ext;
      ply_ext = {10'd0, s1_req_ff.ply};
      if (s_ext >= t_ext) begin
         adj = s_ext + ply_ext;
      end else if (s_ext <= neg_t) begin
         adj = s_ext - ply_ext;
      end else begin
         adj = s_ext;
      end
      if (adj > 18'sd32767) begin
         score_sat = 16'sd32767;
      end else if (adj < -18'sd32767) begin
         score_sat = -16'sd32767;
      end else begin
         score_sat = adj[15:0];
      end
   end

   always_comb begin
      q_item.op    = s1_req_ff.op;
      q_item.key   = s1_req_ff.key;
      q_item.depth = s1_req_ff.new_depth;
      q_item.flag  = s1_req_ff.new_flag;
      q_item.move  = s1_req_ff.new_move;
      q_item.score = score_sat;
      if (32'(idx_full) >= TableDepth) begin
         q_item.index = IdxWidth'(TableDepth - 1);
      end else begin
         q_item.index = idx_full[IdxWidth-1:0];
      end
   end

endmodule

>>> src/htdr_queue.sv
// two-entry queue of classified items between the front and the back
// depends on htdr_pkg
module htdr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  htdr_pkg::item_type         push_item,
   input  logic                       pop,
   output htdr_pkg::item_type         pop_item,
   output htdr_pkg::queue_status_type status
);
   import htdr_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/htdr_back.sv
// back end: table memory, clearing pass, read-modify-write and the result register
// depends on htdr_pkg
module htdr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [3:0]                 depth_lenience,
   input  htdr_pkg::item_type         q_item,
   input  htdr_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output htdr_pkg::back_status_type  status,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output htdr_pkg::rsp_type          rsp_word
);
   import htdr_pkg::*;

   back_state_type      state_ff, state_in;
   logic [IdxWidth-1:0] clr_cnt_ff, clr_cnt_in;
   item_type            cur_ff;
   entry_type           rd_ff;
   entry_type           store_ff [TableDepth];
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;

   logic                hit, lenient, do_rep, out_free, clear_done;
   logic                mem_we, load_rsp;
   logic [IdxWidth-1:0] wr_addr;
   entry_type           wr_data, new_entry;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign clear_done = (clr_cnt_ff == '1);

   always_comb begin
      hit     = (rd_ff.key == cur_ff.key);
      lenient = (9'(cur_ff.depth) + 9'(depth_lenience)) >= 9'(rd_ff.depth);
      do_rep  = (cur_ff.op == OpSave) && (!hit || lenient || cur_ff.flag == FlagExact);
      new_entry.key   = cur_ff.key;
      new_entry.depth = cur_ff.depth;
      new_entry.flag  = cur_ff.flag;
      // a hit with no move keeps the stored move
      new_entry.move  = (cur_ff.move == '0 && hit) ? rd_ff.move : cur_ff.move;
      new_entry.score = cur_ff.score;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BackClear: begin
            if (clear_done) begin
               state_in = BackIdle;
            end
         end
         BackIdle: begin
            if (!q_status.empty) begin
               state_in = BackEval;
            end
         end
         BackEval: begin
            if (out_free) begin
               state_in = BackIdle;
            end
         end
         default: state_in = BackClear;
      endcase
   end

   always_comb begin
      mem_we          = 1'b0;
      wr_addr         = cur_ff.index;
      wr_data         = new_entry;
      q_pop           = 1'b0;
      load_rsp        = 1'b0;
      clr_cnt_in      = clr_cnt_ff;
      status.clearing = 1'b0;
      case (state_ff)
         BackClear: begin
            status.clearing = 1'b1;
            mem_we          = 1'b1;
            wr_addr         = clr_cnt_ff;
            wr_data         = '0;
            clr_cnt_in      = clr_cnt_ff + 1'b1;
         end
         BackIdle: begin
            q_pop = !q_status.empty;
         end
         BackEval: begin
            load_rsp = out_free;
            mem_we   = out_free && do_rep;
         end
         default: begin
            status.clearing = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BackClear;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // single-port style table: one write or one registered read per cycle, never both
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (q_pop) begin
         rd_ff <= store_ff[q_item.index];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (load_rsp) begin
         rsp_ff.hit      <= hit;
         rsp_ff.stored   <= rd_ff;
         rsp_ff.replaced <= do_rep;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

>>> src/hashed_table_with_depth_replacement_core.sv
// Direct-mapped hashed table with depth-preferred replacement. After reset the
// table is cleared one slot per cycle with req_stall held high; csr writes are
// taken during that time. Each request word then passes the front end (index
// multiply) and a two-entry queue; in the back end the idle state reads its
// slot and the eval state compares, writes back and loads the response
// register once the response register is free. The back end reads the next
// word only after the read-modify-write of the last one is done. Write csr
// registers only while no word is in flight.
// top level: csr registers, front end, queue and back end; depends on htdr_pkg, htdr_front, htdr_queue and htdr_back
module hashed_table_with_depth_replacement_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [htdr_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [htdr_pkg::CsrDataW-1:0] csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [63:0]                   req_key,
   input  logic [7:0]                    req_new_depth,
   input  logic [1:0]                    req_new_flag,
   input  logic [15:0]                   req_new_move,
   input  logic signed [15:0]            req_new_score,
   input  logic [7:0]                    req_ply,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [63:0]                   rsp_stored_key,
   output logic [7:0]                    rsp_stored_depth,
   output logic [1:0]                    rsp_stored_flag,
   output logic [15:0]                   rsp_stored_move,
   output logic signed [15:0]            rsp_stored_score,
   output logic                          rsp_replaced
);
   import htdr_pkg::*;

   logic [EntriesW-1:0] table_entries_ff, table_entries_in;
   logic [14:0]         mate_threshold_ff, mate_threshold_in;
   logic [3:0]          depth_lenience_ff, depth_lenience_in;

   req_type          req_word;
   rsp_type          rsp_word;
   item_type         push_item, pop_item;
   logic             q_push, q_pop;
   queue_status_type q_status;
   back_status_type  back_status;

   always_comb begin
      table_entries_in  = table_entries_ff;
      mate_threshold_in = mate_threshold_ff;
      depth_lenience_in = depth_lenience_ff;
      if (csr_write) begin
         case (csr_index)
            CsrTableEntries:  table_entries_in  = csr_data[EntriesW-1:0];
            CsrMateThreshold: mate_threshold_in = csr_data[14:0];
            CsrDepthLenience: depth_lenience_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_entries_ff  <= EntriesReset;
         mate_threshold_ff <= ThresholdReset;
         depth_lenience_ff <= LenienceReset;
      end else begin
         table_entries_ff  <= table_entries_in;
         mate_threshold_ff <= mate_threshold_in;
         depth_lenience_ff <= depth_lenience_in;
      end
   end

   always_comb begin
      req_word.op        = req_op;
      req_word.key       = req_key;
      req_word.new_depth = req_new_depth;
      req_word.new_flag  = req_new_flag;
      req_word.new_move  = req_new_move;
      req_word.new_score = req_new_score;
      req_word.ply       = req_ply;
   end

   htdr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .table_entries  (table_entries_ff),
      .mate_threshold (mate_threshold_ff),
      .q_status       (q_status),
      .back_status    (back_status),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   htdr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   htdr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .depth_lenience (depth_lenience_ff),
      .q_item         (pop_item),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .status         (back_status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word)
   );

   assign rsp_hit          = rsp_word.hit;
   assign rsp_stored_key   = rsp_word.stored.key;
   assign rsp_stored_depth = rsp_word.stored.depth;
   assign rsp_stored_flag  = rsp_word.stored.flag;
   assign rsp_stored_move  = rsp_word.stored.move;
   assign rsp_stored_score = rsp_word.stored.score;
   assign rsp_replaced     = rsp_word.replaced;

endmodule

>>> src/htdr_checker.sv
// port-level checks for the hashed table core, attached by bind
// depends on hashed_table_with_depth_replacement_core
module htdr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_hit,
   input logic [63:0]                   rsp_stored_key,
   input logic [7:0]                    rsp_stored_depth,
   input logic [1:0]                    rsp_stored_flag,
   input logic [15:0]                   rsp_stored_move,
   input logic signed [15:0]            rsp_stored_score,
   input logic                          rsp_replaced
);

   // the clearing pass starts right after reset, so no word may enter
   a_clear_blocks_req: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request not stalled after reset");

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the back end passes through its idle state between words; only a word held behind a stall may follow at once
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !$past(rsp_stall)) |=> !rsp_valid)
      else $error("responses closer than the table read-modify-write allows");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hit)
         && $stable(rsp_stored_key) && $stable(rsp_stored_depth)
         && $stable(rsp_stored_flag) && $stable(rsp_stored_move)
         && $stable(rsp_stored_score) && $stable(rsp_replaced)))
      else $error("stalled response changed");

endmodule

bind hashed_table_with_depth_replacement_core htdr_checker u_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// testbench for hashed_table_with_depth_replacement_core: directed and random probe/save words
// checked against a self-contained table mirror; depends on htdr_pkg and the core
module tb_top;
   import htdr_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CsrTableEntries;
   logic [CsrDataW-1:0] csr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_op = OpProbe;
   logic [63:0]         req_key = '0;
   logic [7:0]          req_new_depth = '0;
   logic [1:0]          req_new_flag = '0;
   logic [15:0]         req_new_move = '0;
   logic signed [15:0]  req_new_score = '0;
   logic [7:0]          req_ply = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_hit;
   logic [63:0]         rsp_stored_key;
   logic [7:0]          rsp_stored_depth;
   logic [1:0]          rsp_stored_flag;
   logic [15:0]         rsp_stored_move;
   logic signed [15:0]  rsp_stored_score;
   logic                rsp_replaced;

   hashed_table_with_depth_replacement_core uut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op), .req_key(req_key),
      .req_new_depth(req_new_depth), .req_new_flag(req_new_flag),
      .req_new_move(req_new_move), .req_new_score(req_new_score), .req_ply(req_ply),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_stored_key(rsp_stored_key), .rsp_stored_depth(rsp_stored_depth),
      .rsp_stored_flag(rsp_stored_flag), .rsp_stored_move(rsp_stored_move),
      .rsp_stored_score(rsp_stored_score), .rsp_replaced(rsp_replaced)
   );

   class table_mirror;
      entry_type          slots[int unsigned];
      rsp_type            pending_lookups[$];
      logic [EntriesW-1:0] entries = EntriesReset;
      logic [14:0]        threshold = ThresholdReset;
      logic [3:0]         lenience = LenienceReset;
      int                 mismatches = 0;
      int                 failures = 0;

      function void set_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
         case (idx)
            CsrTableEntries:  entries = data[EntriesW-1:0];
            CsrMateThreshold: threshold = data[14:0];
            CsrDepthLenience: lenience = data[3:0];
            default: ;
         endcase
      endfunction

      // high half of key * entries, entries clamped to 1..TableDepth
      function int unsigned slot_index(logic [63:0] key);
         logic [127:0] prod;
         int unsigned  n;
         n = entries;
         if (n == 0) n = 1;
         if (n > TableDepth) n = TableDepth;
         prod = {64'd0, key} * 128'(n);
         if (prod[127:64] >= 64'(TableDepth)) return TableDepth - 1;
         return int'(prod[95:64]);
      endfunction

      // push mate-range scores outward by ply, then clamp to +-32767
      function logic signed [15:0] mate_adjust(logic signed [15:0] s, logic [7:0] ply);
         int v;
         int t;
         v = s;
         t = threshold;
         if (v >= t) v = v + int'(ply);
         else if (v <= -t) v = v - int'(ply);
         if (v > 32767) v = 32767;
         if (v < -32767) v = -32767;
         return 16'(v);
      endfunction

      function void note_word(req_type w);
         int unsigned idx;
         entry_type   old;
         entry_type   upd;
         rsp_type     r;
         idx = slot_index(w.key);
         old = slots.exists(idx) ? slots[idx] : '0;
         r.hit = (old.key == w.key);
         r.stored = old;
         r.replaced = 1'b0;
         if (w.op == OpSave && (!r.hit || w.new_flag == FlagExact ||
             int'(w.new_depth) + int'(lenience) >= int'(old.depth))) begin
            r.replaced = 1'b1;
            upd.key = w.key;
            upd.depth = w.new_depth;
            upd.flag = w.new_flag;
            upd.move = (w.new_move == 16'd0 && r.hit) ? old.move : w.new_move;
            upd.score = mate_adjust(w.new_score, w.ply);
            slots[idx] = upd;
         end
         pending_lookups.push_back(r);
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp;
         string   bad;
         if (pending_lookups.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word, key=%h", got.stored.key);
            return;
         end
         exp = pending_lookups.pop_front();
         bad = "";
         if (got.hit !== exp.hit) bad = {bad, " hit"};
         if (got.stored.key !== exp.stored.key) bad = {bad, " key"};
         if (got.stored.depth !== exp.stored.depth) bad = {bad, " depth"};
         if (got.stored.flag !== exp.stored.flag) bad = {bad, " flag"};
         if (got.stored.move !== exp.stored.move) bad = {bad, " move"};
         if (got.stored.score !== exp.stored.score) bad = {bad, " score"};
         if (got.replaced !== exp.replaced) bad = {bad, " replaced"};
         if (bad != "") begin
            failures++;
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch in%s at %0t", bad, $realtime);
               $display("  exp hit=%b key=%h depth=%0d flag=%0d move=%h score=%0d rep=%b",
                        exp.hit, exp.stored.key, exp.stored.depth, exp.stored.flag,
                        exp.stored.move, exp.stored.score, exp.replaced);
               $display("  got hit=%b key=%h depth=%0d flag=%0d move=%h score=%0d rep=%b",
                        got.hit, got.stored.key, got.stored.depth, got.stored.flag,
                        got.stored.move, got.stored.score, got.replaced);
            end
         end
      endfunction
   endclass

   table_mirror mirror = new();
   logic [63:0] key_pool[12];
   int          cur_threshold = ThresholdReset;
   bit          steady = 1'b0;

   always #10 clock = ~clock;

   function automatic bit idle_roll();
      return !steady && ($urandom_range(0, 99) < 38);
   endfunction

   // response side: check the word taken at this edge, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.check_word('{hit: rsp_hit,
                             stored: '{key: rsp_stored_key, depth: rsp_stored_depth,
                                       flag: rsp_stored_flag, move: rsp_stored_move,
                                       score: rsp_stored_score},
                             replaced: rsp_replaced});
      rsp_stall <= idle_roll();
   end

   function automatic req_type mk(logic op, logic [63:0] key, logic [7:0] depth,
                                  logic [1:0] flag, logic [15:0] move,
                                  logic signed [15:0] score, logic [7:0] ply);
      req_type w;
      w.op = op;
      w.key = key;
      w.new_depth = depth;
      w.new_flag = flag;
      w.new_move = move;
      w.new_score = score;
      w.ply = ply;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      offs;
      offs = int'($urandom_range(0, 4)) - 2;
      w.op = ($urandom_range(0, 99) < 60) ? OpSave : OpProbe;
      w.key = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, 11)]
                                           : {$urandom, $urandom};
      w.new_depth = 8'($urandom_range(0, 255));
      w.new_flag = 2'($urandom_range(0, 3));
      w.new_move = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      case ($urandom_range(0, 5))
         0: w.new_score = 16'($urandom);
         1: w.new_score = 16'(cur_threshold + offs);
         2: w.new_score = 16'(-cur_threshold + offs);
         3: begin
            case ($urandom_range(0, 2))
               0: w.new_score = 16'sd32767;
               1: w.new_score = -16'sd32767;
               default: w.new_score = 16'h8000;
            endcase
         end
         4: w.new_score = 16'd0;
         default: w.new_score = 16'(int'($urandom_range(0, 400)) - 200);
      endcase
      w.ply = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      return w;
   endfunction

   task automatic set_csr(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      mirror.set_reg(idx, data);
   endtask

   task automatic apply_settings(logic [16:0] entries, logic [14:0] thr, logic [3:0] len);
      set_csr(CsrTableEntries, entries);
      set_csr(CsrMateThreshold, CsrDataW'(thr));
      set_csr(CsrDepthLenience, CsrDataW'(len));
      csr_write <= 1'b0;
      cur_threshold = thr;
   endtask

   task automatic push_word(req_type w);
      while (idle_roll()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= w.op;
      req_key <= w.key;
      req_new_depth <= w.new_depth;
      req_new_flag <= w.new_flag;
      req_new_move <= w.new_move;
      req_new_score <= w.new_score;
      req_ply <= w.ply;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.note_word(w);
   endtask

   // wait out everything in flight so the csr registers may change
   task automatic drain();
      req_valid <= 1'b0;
      while (mirror.pending_lookups.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      req_type     directed[$];
      logic [16:0] ph_entries[6] = '{17'd0, 17'd1, 17'd8, 17'h1FFFF, 17'd37, 17'd65536};
      logic [14:0] ph_thr[6] = '{15'd0, 15'd32767, 15'd100, 15'd31744, 15'd1, 15'd16000};
      logic [3:0]  ph_len[6] = '{4'd0, 4'd15, 4'd2, 4'd4, 4'd7, 4'd15};
      logic [63:0] k1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // register writes are taken while the table clears
      apply_settings(17'd65536, 15'd31744, 4'd4);

      k1 = 64'h8000_0000_0000_0000;
      directed.push_back(mk(OpProbe, 64'd0, 8'd0, 2'd0, 16'd0, 16'sd0, 8'd0));
      directed.push_back(mk(OpProbe, '1, 8'd0, 2'd0, 16'd0, 16'sd0, 8'd0));
      directed.push_back(mk(OpSave, 64'd0, 8'd0, 2'd0, 16'd0, 16'sd0, 8'd0));
      directed.push_back(mk(OpSave, '1, 8'd255, 2'd3, 16'hFFFF, 16'sd32767, 8'd255));
      directed.push_back(mk(OpProbe, '1, 8'd0, 2'd0, 16'd0, 16'sd0, 8'd0));
      directed.push_back(mk(OpSave, '1, 8'd10, 2'd1, 16'd0, 16'sd100, 8'd5));
      directed.push_back(mk(OpSave, '1, 8'd251, 2'd2, 16'd0, -16'sd32767, 8'd1));
      directed.push_back(mk(OpSave, '1, 8'd0, 2'd3, 16'h1234, 16'h8000, 8'd0));
      directed.push_back(mk(OpSave, k1, 8'd7, 2'd2, 16'h0001, 16'sd31744, 8'd200));
      directed.push_back(mk(OpSave, k1, 8'd2, 2'd1, 16'd0, -16'sd31744, 8'd3));
      directed.push_back(mk(OpSave, k1, 8'd3, 2'd1, 16'hABCD, 16'sd31743, 8'd9));
      directed.push_back(mk(OpSave, k1 + 1, 8'd1, 2'd0, 16'h00FF, -16'sd31745, 8'd4));
      directed.push_back(mk(OpProbe, k1, 8'd0, 2'd0, 16'd0, 16'sd0, 8'd0));
      directed.push_back(mk(OpProbe, 64'h0000_FFFF_FFFF_FFFF, 8'd0, 2'd0, 16'd0, 16'sd0, 8'd0));
      directed.push_back(mk(OpSave, {16{4'h5}}, 8'd128, 2'd0, 16'h8000, -16'sd31745, 8'd255));
      directed.push_back(mk(OpSave, {16{4'hA}}, 8'd127, 2'd1, 16'h7FFF, 16'sd1, 8'd255));
      directed.push_back(mk(OpProbe, {16{4'h5}}, 8'd0, 2'd0, 16'd0, 16'sd0, 8'd0));
      directed.push_back(mk(OpProbe, {16{4'hA}}, 8'hFF, 2'd3, 16'hFFFF, 16'sd0, 8'hFF));
      foreach (directed[i]) push_word(directed[i]);
      drain();

      for (int p = 0; p < 6; p++) begin
         apply_settings(ph_entries[p], ph_thr[p], ph_len[p]);
         key_pool[0] = 64'd0;
         key_pool[1] = '1;
         for (int k = 2; k < 12; k++) key_pool[k] = {$urandom, $urandom};
         // one whole phase runs with both sides streaming back to back
         steady = (p == 3);
         for (int n = 0; n < 75; n++) push_word(random_word());
         drain();
         steady = 1'b0;
      end

      repeat (10) @(posedge clock);
      if (mirror.failures == 0 && mirror.pending_lookups.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
